// File: rtl/sfcrc_pkg.sv
// ----------------------------------------------------------------------------
// sfcrc_pkg
// Types, constants and the byte-wise CRC-16 function of the sensor frame
// decoder.
// ----------------------------------------------------------------------------
package sfcrc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions within the eight-byte reply.
  localparam logic [2:0] POS_CRC_LOW  = 3'd6;
  localparam logic [2:0] POS_CRC_HIGH = 3'd7;

  localparam logic [7:0] MAG_MASK  = 8'h7F;
  localparam logic [7:0] SIGN_MASK = 8'h80;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BUS_FAIL = 2'd1,
    STATUS_CRC_FAIL = 2'd2
  } status_e;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       request_failed;
  } in_word_t;

  // Frame state carried from word to word.
  typedef struct packed {
    logic [2:0]  byte_pos;
    logic [15:0] crc;
    logic [31:0] payload;
    logic [7:0]  crc_low;
  } frame_state_t;

  // Result of one word.
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [15:0] temperature;
    logic [15:0] humidity;
  } result_t;

  // Reflected CRC-16 over one byte, eight bit steps unrolled.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/sfcrc_step.sv
// ----------------------------------------------------------------------------
// sfcrc_step
// Combinational frame step: updates the frame state for one byte and forms
// the result on the last byte of a frame or on a bus failure.
// ----------------------------------------------------------------------------
module sfcrc_step (
  input  sfcrc_pkg::in_word_t     word_i,
  input  sfcrc_pkg::frame_state_t state_i,
  output sfcrc_pkg::frame_state_t state_o,
  output sfcrc_pkg::result_t      result_o
);
  import sfcrc_pkg::*;

  logic [2:0]  pos_eff;
  logic [15:0] crc_eff;
  logic [15:0] rcvd_crc;
  logic [7:0]  b2, b3, b4, b5;
  logic [15:0] mag;
  logic [15:0] temp;

  assign b2 = state_i.payload[31:24];
  assign b3 = state_i.payload[23:16];
  assign b4 = state_i.payload[15:8];
  assign b5 = state_i.payload[7:0];

  assign mag      = {(b4 & MAG_MASK), b5};
  assign temp     = ((b4 & SIGN_MASK) != 8'h00) ? (16'h0000 - mag) : mag;
  assign rcvd_crc = {word_i.rx_byte, state_i.crc_low};

  always_comb begin
    pos_eff  = word_i.frame_start ? 3'd0 : state_i.byte_pos;
    crc_eff  = word_i.frame_start ? CRC_INIT : state_i.crc;
    state_o  = state_i;
    result_o = '{valid: 1'b0, status: STATUS_OK, temperature: 16'h0000, humidity: 16'h0000};

    if (word_i.request_failed) begin
      state_o.byte_pos = 3'd0;
      state_o.crc      = CRC_INIT;
      result_o.valid   = 1'b1;
      result_o.status  = STATUS_BUS_FAIL;
    end else if (pos_eff < POS_CRC_LOW) begin
      state_o.byte_pos = pos_eff + 3'd1;
      state_o.crc      = crc16_byte(crc_eff, word_i.rx_byte);
      state_o.payload  = {state_i.payload[23:0], word_i.rx_byte};
    end else if (pos_eff == POS_CRC_LOW) begin
      state_o.byte_pos = POS_CRC_HIGH;
      state_o.crc      = crc_eff;
      state_o.crc_low  = word_i.rx_byte;
    end else begin
      state_o.byte_pos = 3'd0;
      state_o.crc      = CRC_INIT;
      result_o.valid   = 1'b1;
      if (rcvd_crc == crc_eff) begin
        result_o.status      = STATUS_OK;
        result_o.temperature = temp;
        result_o.humidity    = {b2, b3};
      end else begin
        result_o.status = STATUS_CRC_FAIL;
      end
    end
  end

endmodule

// File: rtl/sensor_frame_crc_decoder.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder
// Decoder for the eight-byte reply of a temperature and humidity sensor.
//
// The block takes the reply one byte per input word and runs a reflected
// CRC-16 (polynomial 0xA001, start value 0xFFFF) over bytes 0 to 5, then
// checks it against bytes 6 and 7, low byte first. On byte 7 it delivers one
// result word: status ok with humidity in tenths of a percent and signed
// temperature in tenths of a degree (converted from sign-magnitude), or a
// checksum failure with zero readings. A word with request_failed set aborts
// the frame and yields a bus-failure result at once; frame_start restarts
// the frame and takes its byte as byte 0. After byte 7 the next byte starts
// a new frame on its own. One word is accepted every cycle: each word is
// registered on input, and a single pass of combinational logic (the CRC
// update with its eight bit steps unrolled) runs between that register and
// the result register. The input stage stalls only while a result is held
// in the output register and the downstream side is not ready.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  input  logic               request_failed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic [15:0]        humidity_tenths_o
);
  import sfcrc_pkg::*;

  // Input register stage.
  logic     in_valid_q;
  in_word_t in_word_q;

  // Frame state.
  frame_state_t state_q, state_d;

  // Output register.
  logic        out_valid_q;
  status_e     status_q;
  logic [15:0] temp_q;
  logic [15:0] hum_q;

  result_t result;
  logic    proc;

  // The word in the input register is processed when the output register
  // is free or is being emptied in this cycle.
  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  sfcrc_step u_step (
    .word_i   (in_word_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= '{rx_byte: rx_byte_i, frame_start: frame_start_i,
                     request_failed: request_failed_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{byte_pos: 3'd0, crc: CRC_INIT, payload: 32'h0, crc_low: 8'h00};
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= result.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && result.valid) begin
      status_q <= result.status;
      temp_q   <= result.temperature;
      hum_q    <= result.humidity;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign temperature_tenths_o = signed'(temp_q);
  assign humidity_tenths_o    = hum_q;

  // A stall of the input side can only come from a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a held result");

  // A bus failure always restarts the frame.
  a_fail_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_word_q.request_failed) |=>
      (state_q.byte_pos == 3'd0 && state_q.crc == CRC_INIT && out_valid_q))
    else $error("bus failure did not restart the frame");

  // Failure results carry zero readings.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_OK) |->
      (temperature_tenths_o == 16'sd0 && humidity_tenths_o == 16'd0))
    else $error("failure result with nonzero readings");

endmodule

// File: tb/sfcrc_tb_pkg.sv
// ----------------------------------------------------------------------------
// sfcrc_tb_pkg
// Reading predictor and result checker for the sensor frame decoder test.
// ----------------------------------------------------------------------------
package sfcrc_tb_pkg;

  import sfcrc_pkg::*;

  typedef struct {
    status_e     status;
    logic [15:0] temperature;
    logic [15:0] humidity;
  } reading_t;

  class frame_checker;

    logic [2:0]  byte_pos;
    logic [15:0] crc;
    logic [31:0] payload;
    logic [7:0]  crc_low;
    reading_t    pending[$];
    int unsigned mismatches;

    function new();
      byte_pos   = '0;
      crc        = CRC_INIT;
      payload    = '0;
      crc_low    = '0;
      mismatches = 0;
    endfunction

    // Reflected CRC-16, one input bit at a time, LSB first.
    static function logic [15:0] fold_crc_byte(logic [15:0] crc_in, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc_in;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    // Advances the frame state by one accepted word and queues any reading.
    function void take_word(logic [7:0] b, logic start, logic failed);
      reading_t    r;
      logic [15:0] mag;
      if (failed) begin
        byte_pos      = '0;
        crc           = CRC_INIT;
        r.status      = STATUS_BUS_FAIL;
        r.temperature = '0;
        r.humidity    = '0;
        pending.push_back(r);
        return;
      end
      if (start) begin
        byte_pos = '0;
        crc      = CRC_INIT;
      end
      if (byte_pos < POS_CRC_LOW) begin
        crc      = fold_crc_byte(crc, b);
        payload  = {payload[23:0], b};
        byte_pos = byte_pos + 3'd1;
      end else if (byte_pos == POS_CRC_LOW) begin
        crc_low  = b;
        byte_pos = byte_pos + 3'd1;
      end else begin
        if ({b, crc_low} == crc) begin
          mag           = {payload[15:8] & MAG_MASK, payload[7:0]};
          r.status      = STATUS_OK;
          r.temperature = ((payload[15:8] & SIGN_MASK) != 8'h00) ? 16'h0000 - mag : mag;
          r.humidity    = payload[31:16];
        end else begin
          r.status      = STATUS_CRC_FAIL;
          r.temperature = '0;
          r.humidity    = '0;
        end
        pending.push_back(r);
        byte_pos = '0;
        crc      = CRC_INIT;
      end
    endfunction

    function void report(string what, int expv, int gotv);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d: %s expected %0d (0x%h) got %0d (0x%h)",
                 mismatches, what, expv, expv, gotv, gotv);
    endfunction

    // Compares one delivered reading with the oldest predicted one.
    function void check_reading(logic [1:0] st, logic [15:0] temp, logic [15:0] hum);
      reading_t r;
      if (pending.size() == 0) begin
        report("unexpected reading, status", -1, int'(st));
        return;
      end
      r = pending.pop_front();
      if (st !== r.status) report("status", int'(r.status), int'(st));
      if (temp !== r.temperature)
        report("temperature", int'($signed(r.temperature)), int'($signed(temp)));
      if (hum !== r.humidity) report("humidity", int'(r.humidity), int'(hum));
    endfunction

  endclass

endpackage

// File: tb/sensor_frame_crc_decoder_test.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_test
// Self-checking test of the sensor frame CRC decoder.
//
// Frames of eight bytes are pushed in one word at a time. A handful of
// directed frames cover negative zero, the temperature extremes, a restart in
// the middle of a frame, a bus abort that overrides frame_start, a checksum
// failure and a frame that starts by wrapping. Random traffic follows: mostly
// well-formed frames with a correct checksum, some with a damaged checksum or
// an abort part way through, and runs of stray bytes. Every accepted word is
// fed to a predictor, and each delivered reading is checked field by field
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module sensor_frame_crc_decoder_test;

  import sfcrc_pkg::*;
  import sfcrc_tb_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 6;
  localparam int TOTAL_WORDS  = 550;
  // From this word on neither side idles, so the tail runs at full rate.
  localparam int QUIET_FROM   = 470;
  // Word counts at which the long output hold-off and the drain pause start.
  localparam int HOLD_AT      = 200;
  localparam int DRAIN_AT     = 350;
  localparam int HOLD_CYCLES  = 300;
  // Cycles waited after the last expected reading to catch any stray late one.
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i;
  logic               frame_start_i;
  logic               request_failed_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic signed [15:0] temperature_tenths_o;
  logic [15:0]        humidity_tenths_o;

  frame_checker readings;
  int           words_sent = 0;
  int           cycles = 0;
  bit           quiet = 1'b0;
  bit           long_hold = 1'b0;

  sensor_frame_crc_decoder u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .rx_byte_i            (rx_byte_i),
    .frame_start_i        (frame_start_i),
    .request_failed_i     (request_failed_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .status_o             (status_o),
    .temperature_tenths_o (temperature_tenths_o),
    .humidity_tenths_o    (humidity_tenths_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** sensor_frame_crc_decoder: FAILED **");
      $finish;
    end
  end

  // Every word that leaves the block is checked at the edge that takes it.
  // The block updates on nonblocking assignments, so the values read here are
  // the ones that were present before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      readings.check_reading(status_o, temperature_tenths_o, humidity_tenths_o);
  end

  // Downstream side. It alternates ready stretches with stall bursts, holds
  // off for a long stretch once when asked so that the block backs up into
  // its input, and stays ready throughout the quiet tail.
  initial begin : receiver
    int n;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 15);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Offers one word and returns at the edge that accepts it. Valid is left
  // high, so back-to-back words keep it asserted without a glitch; a random
  // gap lowers it first.
  task automatic send_word(input logic [7:0] b, input logic start, input logic failed);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    rx_byte_i        <= b;
    frame_start_i    <= start;
    request_failed_i <= failed;
    do @(posedge clk_i); while (!in_ready_o);
    readings.take_word(b, start, failed);
    words_sent++;
  endtask

  // Builds a reply from six body bytes (byte 0 in the low bits) and appends
  // the checksum, low byte first. A nonzero damage mask corrupts it.
  function automatic logic [63:0] make_frame(input logic [47:0] body, input logic [15:0] damage);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = frame_checker::fold_crc_byte(c, body[8*i +: 8]);
    c = c ^ damage;
    return {c[15:8], c[7:0], body};
  endfunction

  // Sends a whole reply. With abort_at in 0..7 the word at that position is
  // replaced by a failed bus request and the rest of the frame is dropped.
  task automatic send_frame(input logic [63:0] frame, input logic start, input int abort_at);
    for (int i = 0; i < 8; i++) begin
      if (i == abort_at) begin
        send_word(8'($urandom), 1'($urandom), 1'b1);
        return;
      end
      send_word(frame[8*i +: 8], (i == 0) ? start : 1'b0, 1'b0);
    end
  endtask

  // Stops offering words until every predicted reading has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (readings.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [47:0] body;
    logic [15:0] damage;
    int          choice;
    int          abort_at;
    int          n;
    bit          hold_done;
    bit          drain_done;

    hold_done        = 1'b0;
    drain_done       = 1'b0;
    readings         = new();
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    rx_byte_i        <= '0;
    frame_start_i    <= 1'b0;
    request_failed_i <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A failed request wins over frame_start and reports a bus failure.
    send_word(8'hFF, 1'b1, 1'b1);
    // Two bytes of a frame that is then restarted by frame_start.
    send_word(8'h55, 1'b1, 1'b0);
    send_word(8'hAA, 1'b0, 1'b0);
    // Negative zero with full-scale humidity.
    send_frame(make_frame(48'h00_80_FF_FF_FF_00, 16'h0000), 1'b1, -1);
    // Starts by wrapping after the previous frame; most negative temperature.
    send_frame(make_frame(48'hFF_FF_00_00_00_00, 16'h0000), 1'b0, -1);
    // Checksum failure on a frame that would read the most positive value.
    send_frame(make_frame(48'hFF_7F_34_12_5A_A5, 16'h8000), 1'b1, -1);
    drain();

    while (words_sent < TOTAL_WORDS) begin
      if (words_sent >= QUIET_FROM) quiet = 1'b1;
      if (!hold_done && words_sent >= HOLD_AT) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && words_sent >= DRAIN_AT) begin
        drain();
        drain_done = 1'b1;
      end
      choice = $urandom_range(0, 19);
      if (choice < 16) begin
        // A reply with random content; some are steered to the corner cases
        // of the temperature and humidity fields.
        body = {16'($urandom), 32'($urandom)};
        case ($urandom_range(0, 7))
          0: body[47:32] = 16'h0080;
          1: body[47:32] = 16'hFFFF;
          2: body[47:32] = 16'hFF7F;
          3: body[31:16] = 16'hFFFF;
          4: body[31:16] = 16'h0000;
          default: ;
        endcase
        damage   = (choice >= 13) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
        abort_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 7)) : -1;
        // A frame that follows stray bytes must be resynchronized by
        // frame_start; an aligned one may also start by wrapping.
        send_frame(make_frame(body, damage),
                   (readings.byte_pos != 3'd0) || ($urandom_range(0, 1) == 1), abort_at);
      end else if (choice < 19) begin
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++)
          send_word(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0);
      end else begin
        send_word(8'($urandom), 1'($urandom), 1'b1);
      end
    end

    in_valid_i <= 1'b0;
    while (readings.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (readings.mismatches == 0 && readings.outstanding() == 0)
      $display("** sensor_frame_crc_decoder: PASSED **");
    else
      $display("** sensor_frame_crc_decoder: FAILED **");
    $finish;
  end

endmodule
